// ----- rtl/core/smpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package smpd_pkg;

  // packet sizes and byte counter width
  localparam int unsigned FULL_PACKET_BYTES  = 8;
  localparam int unsigned BASIC_PACKET_BYTES = 5;
  localparam int unsigned CNT_W              = 4;
  localparam int unsigned IDX_W              = 3;

  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(FULL_PACKET_BYTES);
  localparam logic [CNT_W-1:0] BASIC_CNT = CNT_W'(BASIC_PACKET_BYTES);

  // button groups
  localparam int unsigned STD_BUTTONS = 3;
  localparam int unsigned EXT_BUTTONS = 7;

  // seven-bit scroll fields and extension button byte
  localparam logic [7:0] SEVEN_BIT_MASK = 8'h7F;
  localparam logic [7:0] SEVEN_BIT_SIGN = 8'h40;

  // event slots of one decoded packet, in delivery order
  localparam int unsigned NUM_SLOTS = 13;
  localparam int unsigned SLOT_W    = 4;
  localparam logic [SLOT_W-1:0] SLOT_X   = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_Y   = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_Z   = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_STD = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_EXT = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_END = 4'd12;

  // configuration register addresses (paddr bit 2 selects)
  localparam logic REG_SYNC_MASK  = 1'b0;
  localparam logic REG_SYNC_VALUE = 1'b1;

  localparam logic [7:0] SYNC_MASK_RST  = 8'hF8;
  localparam logic [7:0] SYNC_VALUE_RST = 8'h80;

  typedef enum logic [1:0] {
    EV_X_MOTION = 2'd0,
    EV_Y_MOTION = 2'd1,
    EV_SCROLL   = 2'd2,
    EV_BUTTON   = 2'd3
  } event_kind_t;

  typedef logic signed [9:0] delta_t;

  // signed byte widened to delta width
  function automatic delta_t sext8(input logic [7:0] b);
    return delta_t'({{2{b[7]}}, b});
  endfunction

  // seven-bit field sign extended to delta width
  function automatic delta_t sext7(input logic [7:0] b);
    return delta_t'({{3{b[6]}}, b[6:0]});
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/serial_mouse_packet_decoder_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Serial mouse packet decoder (five-byte sync protocol, 8-byte extension).
// Input channel in_*: one raw mouse byte per item in in_tdata, in_tlast marks
// the end of a read, so a held packet of 5 to 7 bytes is decoded as basic.
// Output channel out_*: one event per item; out_tuser is the event kind,
// out_tdata holds delta, button number and pressed, out_tlast marks the final
// event caused by one input byte.
// Config port cfg_*: sync_mask at address 0, sync_value at address 4.
// Path: an accepted byte is held in the input register, decoded into a pending
// event set once the previous set is done, and its first event is then loaded
// into the output register that drives out_*.
// Throughput: a byte that completes no packet yields no events; a packet yields
// up to 13 events, which the output serializer moves one event a cycle into the
// output register while out_tready does not stall it. The next byte is decoded in
// the cycle the last pending event moves to the output register.
// Reset clears the held byte count, button state, and all valid flags, and
// loads the sync registers with 0xF8 / 0x80. When out_tready is low the
// output register holds its event, the pending set waits, and in_tready drops
// once the input register is also full.
module serial_mouse_packet_decoder_top
  import smpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // end_of_read
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [9:0] delta, [13:10] button_number,
                                       // [14] pressed, [15] zero
  output logic [1:0]       out_tuser,  // [1:0] event_kind
  output logic             out_tlast,  // last
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // configuration registers
  logic [7:0] sync_mask_r;
  logic [7:0] sync_value_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_mask_r  <= SYNC_MASK_RST;
      sync_value_r <= SYNC_VALUE_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SYNC_MASK) begin
        sync_mask_r <= cfg_pwdata[7:0];
      end else begin
        sync_value_r <= cfg_pwdata[7:0];
      end
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SYNC_VALUE) ? {24'd0, sync_value_r}
                                                       : {24'd0, sync_mask_r};

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_eor_r;
  logic       in_acc;
  logic       proc_fire;

  assign in_tready = !in_valid_r || proc_fire;
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_acc) begin
      in_valid_r <= 1'b1;
    end else if (proc_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_eor_r  <= in_tlast;
    end
  end

  // packet store and button state
  logic [7:0]       store_r [FULL_PACKET_BYTES];
  logic [CNT_W-1:0] cnt_r;
  logic [2:0]       std_btn_r;
  logic [6:0]       ext_btn_r;

  // append, resync and decode path
  logic [7:0]       app    [FULL_PACKET_BYTES];
  logic [FULL_PACKET_BYTES-1:0] app_sync;
  logic [CNT_W-1:0] cnt_app;
  logic [CNT_W-1:0] skip;
  logic [7:0]       pkt    [FULL_PACKET_BYTES];
  logic [FULL_PACKET_BYTES-1:0] pkt_sync;
  logic [CNT_W-1:0] cnt_pkt;
  logic [CNT_W-1:0] pidx;
  logic             do_decode;
  logic             is_ext;
  logic [CNT_W-1:0] left_cnt;
  logic [CNT_W-1:0] left_skip;
  logic [CNT_W-1:0] lidx;
  logic [7:0]       store_nxt [FULL_PACKET_BYTES];
  logic [CNT_W-1:0] cnt_nxt;
  delta_t           dx;
  delta_t           dy;
  delta_t           dz;
  logic [2:0]       std_new;
  logic [6:0]       ext_new;
  logic [2:0]       std_chg;
  logic [6:0]       ext_chg;
  logic [NUM_SLOTS-1:0] set_mask;

  // append the new byte where there is room
  always_comb begin
    for (int i = 0; i < FULL_PACKET_BYTES; i++) begin
      app[i]      = (CNT_W'(i) == cnt_r) ? in_byte_r : store_r[i];
      app_sync[i] = ((app[i] & sync_mask_r) == sync_value_r);
    end
    cnt_app = (cnt_r == FULL_CNT) ? FULL_CNT : cnt_r + CNT_W'(1);
  end

  // drop leading bytes that are not sync bytes
  always_comb begin
    skip = cnt_app;
    for (int i = FULL_PACKET_BYTES - 1; i >= 0; i--) begin
      if (CNT_W'(i) < cnt_app && app_sync[i]) begin
        skip = CNT_W'(i);
      end
    end
    for (int i = 0; i < FULL_PACKET_BYTES; i++) begin
      pidx        = CNT_W'(i) + skip;
      pkt[i]      = app[i];
      pkt_sync[i] = app_sync[i];
      if (pidx < FULL_CNT) begin
        pkt[i]      = app[pidx[IDX_W-1:0]];
        pkt_sync[i] = app_sync[pidx[IDX_W-1:0]];
      end
    end
    cnt_pkt = cnt_app - skip;
  end

  // packet kind and the bytes left after it
  always_comb begin
    do_decode = (cnt_pkt == FULL_CNT) || (in_eor_r && cnt_pkt >= BASIC_CNT);
    is_ext    = (cnt_pkt == FULL_CNT) && !pkt_sync[5] && !pkt_sync[6] && !pkt_sync[7];
    left_cnt  = cnt_pkt - BASIC_CNT;
    left_skip = left_cnt;
    for (int l = 2; l >= 0; l--) begin
      if (CNT_W'(l) < left_cnt && pkt_sync[BASIC_PACKET_BYTES + l]) begin
        left_skip = CNT_W'(l);
      end
    end
    for (int i = 0; i < FULL_PACKET_BYTES; i++) begin
      lidx         = BASIC_CNT + left_skip + CNT_W'(i);
      store_nxt[i] = pkt[i];
      if (do_decode && !is_ext && lidx < FULL_CNT) begin
        store_nxt[i] = pkt[lidx[IDX_W-1:0]];
      end
    end
    if (!do_decode) begin
      cnt_nxt = cnt_pkt;
    end else if (is_ext) begin
      cnt_nxt = '0;
    end else begin
      cnt_nxt = left_cnt - left_skip;
    end
  end

  // motion sums and button changes
  always_comb begin
    dx      = sext8(pkt[1]) + sext8(pkt[3]);
    dy      = delta_t'(0) - (sext8(pkt[2]) + sext8(pkt[4]));
    dz      = sext7(pkt[5] & SEVEN_BIT_MASK) + sext7(pkt[6] & SEVEN_BIT_MASK);
    std_new = pkt[0][2:0];
    ext_new = pkt[7][6:0];
    std_chg = std_btn_r ^ std_new;
    ext_chg = is_ext ? (ext_btn_r ^ ext_new) : 7'd0;
    set_mask = '0;
    if (do_decode) begin
      set_mask[SLOT_X]                            = (dx != '0);
      set_mask[SLOT_Y]                            = (dy != '0);
      set_mask[SLOT_Z]                            = is_ext && (dz != '0);
      set_mask[SLOT_STD +: STD_BUTTONS]           = std_chg;
      set_mask[SLOT_EXT +: EXT_BUTTONS]           = ext_chg;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      for (int i = 0; i < FULL_PACKET_BYTES; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      std_btn_r <= '0;
      ext_btn_r <= '0;
    end else if (proc_fire) begin
      cnt_r <= cnt_nxt;
      if (do_decode) begin
        std_btn_r <= std_new;
      end
      if (do_decode && is_ext) begin
        ext_btn_r <= ext_new;
      end
    end
  end

  // pending event set of one packet
  logic [NUM_SLOTS-1:0] pend_r;
  logic [NUM_SLOTS-1:0] pend_nxt;
  delta_t               dx_r;
  delta_t               dy_r;
  delta_t               dz_r;
  logic [2:0]           std_new_r;
  logic [6:0]           ext_new_r;

  // serializer: lowest pending slot goes out first
  logic [SLOT_W-1:0]    sel;
  logic [NUM_SLOTS-1:0] sel_bit;
  logic                 sel_last;
  logic                 out_load;
  logic                 pend_done;
  logic [SLOT_W-1:0]    sel_off;
  event_kind_t          ev_kind;
  delta_t               ev_delta;
  logic [3:0]           ev_button;
  logic                 ev_pressed;

  always_comb begin
    sel = SLOT_END;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        sel = SLOT_W'(i);
      end
    end
    sel_bit  = pend_r & (~pend_r + NUM_SLOTS'(1));
    sel_last = ((pend_r & ~sel_bit) == '0);
  end

  assign out_load  = (pend_r != '0) && (!out_tvalid || out_tready);
  assign pend_done = (pend_r == '0) || (out_load && sel_last);
  assign proc_fire = in_valid_r && pend_done;

  always_comb begin
    if (proc_fire) begin
      pend_nxt = set_mask;
    end else if (out_load) begin
      pend_nxt = pend_r & ~sel_bit;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      dx_r      <= dx;
      dy_r      <= dy;
      dz_r      <= dz;
      std_new_r <= std_new;
      ext_new_r <= ext_new;
    end
  end

  // fields of the selected event
  always_comb begin
    ev_kind    = EV_BUTTON;
    ev_delta   = '0;
    ev_button  = '0;
    ev_pressed = 1'b0;
    sel_off    = '0;
    case (sel) inside
      SLOT_X: begin
        ev_kind  = EV_X_MOTION;
        ev_delta = dx_r;
      end
      SLOT_Y: begin
        ev_kind  = EV_Y_MOTION;
        ev_delta = dy_r;
      end
      SLOT_Z: begin
        ev_kind  = EV_SCROLL;
        ev_delta = dz_r;
      end
      [SLOT_STD:SLOT_EXT - 4'd1]: begin
        // standard bit i reports as button 2 - i
        sel_off    = sel - SLOT_STD;
        ev_button  = 4'(STD_BUTTONS - 1) - sel_off;
        ev_pressed = !std_new_r[sel_off[1:0]];
      end
      default: begin
        // extension bit k reports as button 3 + k
        sel_off    = sel - SLOT_EXT;
        ev_button  = sel - SLOT_STD;
        ev_pressed = !ext_new_r[sel_off[2:0]];
      end
    endcase
  end

  // output register
  logic        out_valid_r;
  event_kind_t out_kind_r;
  delta_t      out_delta_r;
  logic [3:0]  out_button_r;
  logic        out_pressed_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r    <= ev_kind;
      out_delta_r   <= ev_delta;
      out_button_r  <= ev_button;
      out_pressed_r <= ev_pressed;
      out_last_r    <= sel_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pressed_r, out_button_r, out_delta_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ----- test/tb_serial_mouse_packet_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_serial_mouse_packet_decoder_top;
  import smpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 12;

  typedef struct {
    logic [7:0] data;
    logic       end_of_read;
  } mouse_byte_t;

  typedef struct {
    event_kind_t kind;
    delta_t      delta;
    logic [3:0]  button;
    logic        pressed;
    logic        last;
  } mouse_event_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tlast = 1'b0;    // end_of_read
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [9:0] delta, [13:10] button_number, [14] pressed
  logic [1:0]  out_tuser;          // [1:0] event_kind
  logic        out_tlast;          // last
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  serial_mouse_packet_decoder_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // mouse bytes waiting to be sent and events still to arrive
  mouse_byte_t  pending_bytes[$];
  mouse_event_t expected_events[$];
  mouse_event_t step_events[$];

  // decoder state as seen by the predictor
  logic [7:0] sync_mask_q  = SYNC_MASK_RST;
  logic [7:0] sync_value_q = SYNC_VALUE_RST;
  logic [7:0] held_bytes[FULL_PACKET_BYTES];
  int         held_n = 0;
  logic [2:0] std_buttons = 3'b000;
  logic [6:0] ext_buttons = 7'b0000000;

  int   fail_count = 0;
  int   idle_cycles = 0;
  bit   byte_taken = 1'b0;
  int   send_gap = 0;
  int   stall_left = 0;
  bit   quiet_sender = 1'b0;
  bit   quiet_receiver = 1'b0;
  bit   hold_request = 1'b0;
  bit   hold_served = 1'b0;
  mouse_byte_t next_byte;

  function automatic bit is_sync(logic [7:0] b);
    return (b & sync_mask_q) == sync_value_q;
  endfunction

  function automatic int signed_byte(logic [7:0] b);
    return int'($signed(b));
  endfunction

  // seven-bit field, bit 6 taken as sign
  function automatic int signed_seven(logic [7:0] b);
    return int'($signed({b[6], b[6:0]}));
  endfunction

  function automatic void add_event(event_kind_t k, int d, int btn, logic pr);
    mouse_event_t ev;
    ev.kind    = k;
    ev.delta   = d[9:0];
    ev.button  = btn[3:0];
    ev.pressed = pr;
    ev.last    = 1'b0;
    step_events.insert(step_events.size(), ev);
  endfunction

  function automatic void drop_front(int k);
    if (k > held_n) k = held_n;
    for (int i = 0; i + k < held_n; i++) held_bytes[i] = held_bytes[i + k];
    held_n -= k;
  endfunction

  function automatic void resync_store();
    int k;
    k = 0;
    while (k < held_n && !is_sync(held_bytes[k])) k++;
    drop_front(k);
  endfunction

  // one packet: motion, scroll, then button changes
  function automatic void decode_packet();
    int         dx;
    int         dy;
    int         dz;
    bit         ext;
    logic [2:0] new_std;
    logic [6:0] new_ext;
    dx  = signed_byte(held_bytes[1]) + signed_byte(held_bytes[3]);
    dy  = signed_byte(held_bytes[2]) + signed_byte(held_bytes[4]);
    ext = held_n >= FULL_PACKET_BYTES && !is_sync(held_bytes[5]) &&
          !is_sync(held_bytes[6]) && !is_sync(held_bytes[7]);
    if (dx != 0) add_event(EV_X_MOTION, dx, 0, 1'b0);
    if (dy != 0) add_event(EV_Y_MOTION, -dy, 0, 1'b0);
    if (ext) begin
      dz = signed_seven(held_bytes[5]) + signed_seven(held_bytes[6]);
      if (dz != 0) add_event(EV_SCROLL, dz, 0, 1'b0);
    end
    // standard buttons are active low and numbered in reverse
    new_std = held_bytes[0][2:0];
    for (int i = 0; i < STD_BUTTONS; i++)
      if (std_buttons[i] != new_std[i]) add_event(EV_BUTTON, 0, 2 - i, ~new_std[i]);
    std_buttons = new_std;
    if (ext) begin
      new_ext = held_bytes[7][6:0];
      for (int i = 0; i < EXT_BUTTONS; i++)
        if (ext_buttons[i] != new_ext[i])
          add_event(EV_BUTTON, 0, STD_BUTTONS + i, ~new_ext[i]);
      ext_buttons = new_ext;
      drop_front(FULL_PACKET_BYTES);
    end else begin
      drop_front(BASIC_PACKET_BYTES);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eor);
    mouse_event_t ev;
    step_events.delete();
    if (held_n < FULL_PACKET_BYTES) begin
      held_bytes[held_n] = b;
      held_n++;
    end
    resync_store();
    while (held_n >= FULL_PACKET_BYTES || (eor && held_n >= BASIC_PACKET_BYTES)) begin
      decode_packet();
      resync_store();
    end
    if (step_events.size() != 0) begin
      ev = step_events[step_events.size() - 1];
      ev.last = 1'b1;
      step_events[step_events.size() - 1] = ev;
    end
    foreach (step_events[i])
      expected_events.insert(expected_events.size(), step_events[i]);
  endfunction

  function automatic void check_event();
    mouse_event_t want;
    if (expected_events.size() == 0) begin
      $error("event with none expected: kind %0d data 0x%04h", out_tuser, out_tdata);
      fail_count++;
    end else begin
      want = expected_events.pop_front();
      if (out_tuser !== want.kind) begin
        $error("event_kind: expected %0d, got %0d", want.kind, out_tuser);
        fail_count++;
      end
      if (out_tdata[9:0] !== want.delta) begin
        $error("delta: expected %0d, got %0d", want.delta, $signed(out_tdata[9:0]));
        fail_count++;
      end
      if (out_tdata[13:10] !== want.button) begin
        $error("button_number: expected %0d, got %0d", want.button, out_tdata[13:10]);
        fail_count++;
      end
      if (out_tdata[14] !== want.pressed) begin
        $error("pressed: expected %0d, got %0d", want.pressed, out_tdata[14]);
        fail_count++;
      end
      if (out_tlast !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, out_tlast);
        fail_count++;
      end
    end
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // accepted items, checking and watchdog
  always @(posedge clk) begin
    byte_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        byte_taken = 1'b1;
        predict_byte(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) check_event();
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout with %0d events outstanding", expected_events.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  // byte driver
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || byte_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        next_byte = pending_bytes.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_byte.data;
        in_tlast  <= next_byte.end_of_read;
        send_gap  = pick_gap(quiet_sender);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // event receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (hold_request && !hold_served) begin
      hold_served = 1'b1;
      stall_left  = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap(quiet_receiver);
    end
  end

  task automatic push_byte(logic [7:0] d, logic eor);
    mouse_byte_t b;
    b.data        = d;
    b.end_of_read = eor;
    pending_bytes.insert(pending_bytes.size(), b);
  endtask

  function automatic logic [7:0] sync_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return (sync_value_q & sync_mask_q) | (r & ~sync_mask_q);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] extremes[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 3) == 0) return extremes[2'($urandom_range(0, 3))];
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] nonsync_byte();
    logic [7:0] r;
    r = 8'($urandom);
    for (int i = 0; i < 8 && is_sync(r); i++) r = 8'($urandom);
    return r;
  endfunction

  task automatic write_reg(logic sel, logic [7:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {sel, 2'b00};
    cfg_pwdata  <= {24'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_tvalid || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random packets: mostly well formed, some broken, some noise
  task automatic fill_random(int count);
    int queued;
    int r;
    int extra;
    queued = 0;
    while (queued < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        push_byte(sync_byte(), 1'b0);
        repeat (4) push_byte(plain_byte(), 1'b0);
        push_byte(nonsync_byte(), 1'b0);
        push_byte(nonsync_byte(), 1'b0);
        push_byte(nonsync_byte(), $urandom_range(0, 3) == 0);
        queued += 8;
      end else if (r < 75) begin
        extra = $urandom_range(0, 2);
        push_byte(sync_byte(), 1'b0);
        repeat (3) push_byte(plain_byte(), 1'b0);
        repeat (extra) push_byte(plain_byte(), 1'b0);
        push_byte(nonsync_byte(), 1'b1);
        queued += 5 + extra;
      end else if (r < 85) begin
        extra = $urandom_range(0, 6);
        push_byte(sync_byte(), 1'b0);
        repeat (extra) push_byte(plain_byte(), 1'b0);
        push_byte(sync_byte(), $urandom_range(0, 3) == 0);
        queued += 2 + extra;
      end else begin
        extra = $urandom_range(1, 3);
        repeat (extra) push_byte(plain_byte(), $urandom_range(0, 3) == 0);
        queued += extra;
      end
    end
  endtask

  task automatic run_phase(logic [7:0] mask, logic [7:0] value, int count);
    write_reg(REG_SYNC_MASK, mask);
    write_reg(REG_SYNC_VALUE, value);
    sync_mask_q  = mask;
    sync_value_q = value;
    fill_random(count);
    wait_idle();
  endtask

  initial begin
    logic [7:0] rand_mask;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // noise ahead of the first sync byte
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // basic packet closed by end of read, largest motion, first release of all buttons
    push_byte(8'h87, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b1);
    // extended packet with every event: most negative motion and scroll
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h40, 1'b0);
    push_byte(8'h7F, 1'b0);
    // extended packet with small motion, largest scroll, all extension buttons down
    push_byte(8'h85, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h3F, 1'b0);
    push_byte(8'h3F, 1'b0);
    push_byte(8'h00, 1'b1);
    // short read that decodes nothing
    push_byte(8'h82, 1'b1);
    wait_idle();

    run_phase(8'hF8, 8'h80, 90);
    run_phase(8'hFF, 8'hFF, 40);
    quiet_sender   = 1'b1;
    quiet_receiver = 1'b1;
    run_phase(8'h00, 8'h00, 30);
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
    hold_request   = 1'b1;
    run_phase(8'h80, 8'h80, 45);
    run_phase(8'h0F, 8'h10, 10);
    rand_mask = 8'($urandom);
    run_phase(rand_mask, rand_mask & 8'($urandom), 30);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/smpd_pkg.sv
rtl/core/serial_mouse_packet_decoder_top.sv
test/tb_serial_mouse_packet_decoder_top.sv
